FILE: src/mmrp_pkg.sv
// mmrp_pkg: shared types, constants and the CRC-16/MODBUS byte step
// for the meter response parser. No dependencies.
package mmrp_pkg;

    localparam int MAX_FRAME_DEF = 64;
    localparam int FIELD_LEN     = 21;
    localparam int QDEPTH        = 4;
    localparam int PTR_W         = 2;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [7:0] SLAVE_RST  = 8'h01;
    localparam logic [7:0] FUNC_RST   = 8'h04;
    localparam logic [6:0] MINLEN_RST = 7'd25;
    localparam logic [6:0] MINLEN_LO  = 7'd21;

    localparam logic [4:0] OFS_NONE = 5'd31;

    localparam logic [1:0] CFG_SLAVE  = 2'd0;
    localparam logic [1:0] CFG_FUNC   = 2'd1;
    localparam logic [1:0] CFG_MINLEN = 2'd2;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_SHORT = 2'd1,
        STAT_CRC   = 2'd2,
        STAT_ID    = 2'd3
    } t_status;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_end;
    } t_in_word;

    typedef struct packed {
        t_status     status;
        logic [15:0] voltage_raw;
        logic [31:0] current_ma;
        logic [31:0] power_dw;
        logic [31:0] energy_wh;
        logic [15:0] frequency_raw;
        logic [15:0] power_factor_raw;
    } t_out_word;

    typedef struct packed {
        logic [7:0] slave_address;
        logic [7:0] function_code;
        logic [6:0] min_length;
    } t_cfg;

    // classified byte handed from front to back
    typedef struct packed {
        logic [7:0] data;
        logic [4:0] offset;   // field offset, OFS_NONE past the fields
        logic       store;    // within MAX_FRAME
        logic       crc_en;   // byte two places back enters the CRC
        logic       last;
        logic       short_frm;
    } t_token;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

FILE: src/mmrp_front.sv
// mmrp_front: counts bytes of the frame and classifies each word into a token.
// Depends on mmrp_pkg.
module mmrp_front
    import mmrp_pkg::*;
#(
    parameter int MAX_FRAME = MAX_FRAME_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_in_word   i_in_word,
    input  logic [6:0] i_min_length,
    input  t_qstat     i_qstat,
    output logic       o_in_stall,
    output logic       o_push,
    output t_token     o_token
);
    localparam int CW   = $clog2(MAX_FRAME + 1);
    localparam int CMPW = (CW > 7) ? CW : 7;

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [6:0]    need;
    logic          store;

    assign o_in_stall = i_qstat.full;
    assign o_push     = i_in_valid && !i_qstat.full;

    assign store   = r_count < CW'(MAX_FRAME);
    assign n_count = store ? r_count + 1'b1 : r_count;
    assign need    = (i_min_length < MINLEN_LO) ? MINLEN_LO : i_min_length;

    always_comb begin
        o_token.data      = i_in_word.rx_byte;
        o_token.offset    = (r_count < CW'(FIELD_LEN)) ? r_count[4:0] : OFS_NONE;
        o_token.store     = store;
        o_token.crc_en    = r_count >= CW'(2);
        o_token.last      = i_in_word.frame_end;
        o_token.short_frm = CMPW'(n_count) < CMPW'(need);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (o_push) begin
            r_count <= i_in_word.frame_end ? '0 : n_count;
        end
    end

endmodule

FILE: src/mmrp_fifo.sv
// mmrp_fifo: short token queue between front and back.
// Depends on mmrp_pkg.
module mmrp_fifo
    import mmrp_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_token i_token,
    input  logic   i_pop,
    output t_token o_token,
    output t_qstat o_qstat
);
    t_token           r_mem [QDEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W:0]   r_fill;

    assign o_token       = r_mem[r_rd_ptr];
    assign o_qstat.full  = r_fill == (PTR_W + 1)'(QDEPTH);
    assign o_qstat.empty = r_fill == '0;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_token;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (i_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            if (i_push && !i_pop)      r_fill <= r_fill + 1'b1;
            else if (!i_push && i_pop) r_fill <= r_fill - 1'b1;
        end
    end

endmodule

FILE: src/mmrp_back.sv
// mmrp_back: CRC, field capture, frame checks and the output register.
// Depends on mmrp_pkg.
module mmrp_back
    import mmrp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_token    i_token,
    input  t_qstat    i_qstat,
    input  t_cfg      i_cfg,
    input  logic      i_out_stall,
    output logic      o_pop,
    output logic      o_out_valid,
    output t_out_word o_out_word
);
    logic [15:0] r_crc;
    logic [7:0]  r_t0;
    logic [7:0]  r_t1;
    logic [7:0]  r_fld [FIELD_LEN];
    logic        r_out_valid;
    t_out_word   r_out;

    logic [15:0] upd_crc;
    logic [7:0]  upd_t0;
    logic [7:0]  upd_t1;
    logic [7:0]  upd_fld [FIELD_LEN];
    t_status     status;
    t_out_word   n_out;
    logic        load;

    assign o_pop = !i_qstat.empty && (!i_token.last || !r_out_valid || !i_out_stall);
    assign load  = o_pop && i_token.last;

    assign upd_crc = (i_token.store && i_token.crc_en) ? crc_byte(r_crc, r_t1) : r_crc;
    assign upd_t1  = i_token.store ? r_t0 : r_t1;
    assign upd_t0  = i_token.store ? i_token.data : r_t0;

    always_comb begin
        for (int i = 0; i < FIELD_LEN; i++) begin
            upd_fld[i] = (i_token.store && i_token.offset == 5'(i)) ? i_token.data : r_fld[i];
        end
    end

    always_comb begin
        priority if (i_token.short_frm) begin
            status = STAT_SHORT;
        end else if (upd_crc != {upd_t0, upd_t1}) begin
            status = STAT_CRC;
        end else if (upd_fld[0] != i_cfg.slave_address
                     || upd_fld[1] != i_cfg.function_code) begin
            status = STAT_ID;
        end else begin
            status = STAT_OK;
        end
    end

    always_comb begin
        n_out = '0;
        n_out.status = status;
        if (status == STAT_OK) begin
            n_out.voltage_raw      = {upd_fld[3], upd_fld[4]};
            n_out.current_ma       = {upd_fld[7], upd_fld[8], upd_fld[5], upd_fld[6]};
            n_out.power_dw         = {upd_fld[11], upd_fld[12], upd_fld[9], upd_fld[10]};
            n_out.energy_wh        = {upd_fld[15], upd_fld[16], upd_fld[13], upd_fld[14]};
            n_out.frequency_raw    = {upd_fld[17], upd_fld[18]};
            n_out.power_factor_raw = {upd_fld[19], upd_fld[20]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            for (int i = 0; i < FIELD_LEN; i++) begin
                r_fld[i] <= upd_fld[i];
            end
        end
        if (load) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc       <= CRC_INIT;
            r_t0        <= '0;
            r_t1        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_crc <= i_token.last ? CRC_INIT : upd_crc;
                r_t0  <= i_token.last ? '0 : upd_t0;
                r_t1  <= i_token.last ? '0 : upd_t1;
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

FILE: src/modbus_meter_response_parser.sv
// modbus_meter_response_parser: top level, configuration registers and assertions.
// Depends on mmrp_pkg, mmrp_front, mmrp_fifo, mmrp_back.
//
//  channel  direction  handshake                  word
//  in       input      i_in_valid / o_in_stall    i_in_word  (rx_byte, frame_end)
//  out      output     o_out_valid / i_out_stall  o_out_word (status and meter fields)
//  cfg      input      i_cfg_we                   i_cfg_idx, i_cfg_data
//
// One input word per cycle while the queue is not full; the eight CRC steps are
// unrolled into combinational logic. A frame's last byte is registered in the
// 4-entry token queue, and its result then in the output register.
// Synchronous active-low reset; no clearing pass.
// Output stall holds only frame-end tokens; other bytes keep draining, and
// the input stalls once the queue fills behind a held frame-end word.
module modbus_meter_response_parser
    import mmrp_pkg::*;
#(
    parameter int MAX_FRAME = MAX_FRAME_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word,
    input  logic      i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data
);
    t_cfg   r_cfg;
    t_token front_tok;
    t_token queue_tok;
    t_qstat qstat;
    logic   push;
    logic   pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.slave_address <= SLAVE_RST;
            r_cfg.function_code <= FUNC_RST;
            r_cfg.min_length    <= MINLEN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SLAVE:  r_cfg.slave_address <= i_cfg_data;
                CFG_FUNC:   r_cfg.function_code <= i_cfg_data;
                CFG_MINLEN: r_cfg.min_length    <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    mmrp_front #(.MAX_FRAME(MAX_FRAME)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_word    (i_in_word),
        .i_min_length (r_cfg.min_length),
        .i_qstat      (qstat),
        .o_in_stall   (o_in_stall),
        .o_push       (push),
        .o_token      (front_tok)
    );

    mmrp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_token (front_tok),
        .i_pop   (pop),
        .o_token (queue_tok),
        .o_qstat (qstat)
    );

    mmrp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_token     (queue_tok),
        .i_qstat     (qstat),
        .i_cfg       (r_cfg),
        .i_out_stall (i_out_stall),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

    a_queue_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(qstat.full && qstat.empty))
        else $error("queue full and empty together");

    a_end_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_in_word.frame_end && qstat.empty && !o_out_valid)
        |=> ##1 o_out_valid)
        else $error("frame end did not produce a result");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.status != STAT_OK)
        |-> (o_out_word.voltage_raw == '0 && o_out_word.current_ma == '0
             && o_out_word.power_dw == '0 && o_out_word.energy_wh == '0
             && o_out_word.frequency_raw == '0 && o_out_word.power_factor_raw == '0))
        else $error("failed frame carries data");

endmodule
